// File: rtl/core/qrs_pkg.sv
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Shared widths, tolerance reset value and root count codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int TOL_WIDTH      = 32;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = 32'd43;

   typedef enum logic [1:0] {
      CNT_NONE     = 2'd0,
      CNT_ONE      = 2'd1,
      CNT_TWO      = 2'd2,
      CNT_INFINITE = 2'd3
   } root_count_type;

endpackage

// File: rtl/core/qrs_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Carries one word of coefficients with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface qrs_req_if #(
   parameter int DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] coef_a;
   logic signed [DATA_WIDTH-1:0] coef_b;
   logic signed [DATA_WIDTH-1:0] coef_c;

   modport source (output valid, coef_a, coef_b, coef_c, input ready);
   modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// File: rtl/core/qrs_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel
// Carries one word of roots with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface qrs_rsp_if #(
   parameter int DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   root_count;
   logic signed [DATA_WIDTH-1:0] root_first;
   logic signed [DATA_WIDTH-1:0] root_second;
   logic                         saturated;

   modport source (output valid, root_count, root_first, root_second, saturated,
                   input ready);
   modport sink   (input valid, root_count, root_first, root_second, saturated,
                   output ready);
endinterface

// File: rtl/core/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// Quadratic root solver core
// Solves a*x^2+b*x+c=0 on signed fixed-point coefficients in a deep pipeline.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// req       in         coef_a, coef_b, coef_c
// rsp       out        root_count, root_first, root_second, saturated
// csr       in         zero_tolerance write
//
// A word enters every cycle while rsp does not stall. At the default widths the
// pipeline has four front stages, one stage per square root bit (34), one
// stage per quotient bit of the two restoring dividers (83) and the output register.
// Reset clears all valid bits and loads the tolerance. A stall on rsp freezes
// the whole pipeline, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core #(
   parameter int DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   qrs_req_if.sink                      req,
   qrs_rsp_if.source                    rsp,
   input  logic                         csr_write_enable,
   input  logic [qrs_pkg::TOL_WIDTH-1:0] csr_write_data
);
   localparam int W   = DATA_WIDTH;
   localparam int DW  = 2 * W + 3;          // discriminant magnitude width
   localparam int SW  = (DW + 1) / 2;       // root width
   localparam int NW  = W + SW + 1;         // numerator magnitude width
   localparam int QW  = NW + FRAC_BITS;     // shifted numerator / quotient
   localparam int DNW = W + 1;              // denominator width
   localparam int RW  = DNW + 1;            // partial remainder width
   localparam int NS  = 4;                  // front stages
   localparam int SQ  = SW;                 // sqrt stages
   localparam int DV  = QW;                 // divide stages
   localparam int NST = NS + SQ + DV + 1;

   typedef struct packed {
      logic            na, nb, nc;
      logic [W-1:0]    ma, mb, mc;
   } front_type;

   typedef struct packed {
      logic [1:0]      cnt;
      logic            n1, n2;
      logic [NW-1:0]   m1, m2;
      logic [DNW-1:0]  den;
   } quot_type;

   logic                      stall;
   logic [NST-1:0]            vld_ff;
   logic [qrs_pkg::TOL_WIDTH-1:0] tol_ff;

   assign stall     = rsp.valid & ~rsp.ready;
   assign req.ready = ~stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= qrs_pkg::TOL_RESET;
      end else if (csr_write_enable) begin
         tol_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (!stall) begin
         vld_ff <= {vld_ff[NST-2:0], req.valid};
      end
   end

   // Stage 0: sign and magnitude.
   front_type s0_ff;
   always_ff @(posedge clock) begin
      if (!stall) begin
         s0_ff.na <= req.coef_a[W-1];
         s0_ff.nb <= req.coef_b[W-1];
         s0_ff.nc <= req.coef_c[W-1];
         s0_ff.ma <= req.coef_a[W-1] ? W'(-req.coef_a) : W'(req.coef_a);
         s0_ff.mb <= req.coef_b[W-1] ? W'(-req.coef_b) : W'(req.coef_b);
         s0_ff.mc <= req.coef_c[W-1] ? W'(-req.coef_c) : W'(req.coef_c);
      end
   end

   // Stage 1: products.
   front_type        s1_ff;
   logic [2*W-1:0]   b2_ff, ac_ff;
   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_ff <= s0_ff;
         b2_ff <= s0_ff.mb * s0_ff.mb;
         ac_ff <= s0_ff.ma * s0_ff.mc;
      end
   end

   // Stage 2: signed discriminant.
   front_type        s2_ff;
   logic [DW-1:0]    d_ff;
   logic             dneg_ff;
   logic [DW-1:0]    b2x, ac4x;
   assign b2x  = DW'(b2_ff);
   assign ac4x = DW'({ac_ff, 2'b00});
   always_ff @(posedge clock) begin
      if (!stall) begin
         s2_ff <= s1_ff;
         if (s1_ff.na != s1_ff.nc) begin
            d_ff <= b2x + ac4x; dneg_ff <= 1'b0;
         end else if (b2x >= ac4x) begin
            d_ff <= b2x - ac4x; dneg_ff <= 1'b0;
         end else begin
            d_ff <= ac4x - b2x; dneg_ff <= 1'b1;
         end
      end
   end

   // Stage 3: classify.
   front_type        s3_ff;
   logic [DW-1:0]    d3_ff;
   logic [1:0]       cls_ff;
   always_ff @(posedge clock) begin
      if (!stall) begin
         s3_ff <= s2_ff;
         d3_ff <= d_ff;
         if (s2_ff.ma == '0) begin
            if (s2_ff.mb == '0) begin
               cls_ff <= (s2_ff.mc == '0) ? qrs_pkg::CNT_INFINITE : qrs_pkg::CNT_NONE;
            end else begin
               cls_ff <= qrs_pkg::CNT_ONE;
            end
         end else if (d_ff <= DW'(tol_ff)) begin
            cls_ff <= qrs_pkg::CNT_ONE;
         end else if (!dneg_ff) begin
            cls_ff <= qrs_pkg::CNT_TWO;
         end else begin
            cls_ff <= qrs_pkg::CNT_NONE;
         end
      end
   end

   // Square root, one result bit a stage.
   front_type       sq_f_ff [SQ+1];
   logic [1:0]      sq_c_ff [SQ+1];
   logic [DW+1:0]   sq_r_ff [SQ+1];
   logic [SW-1:0]   sq_q_ff [SQ+1];
   logic [2*SW-1:0] sq_d_ff [SQ+1];

   always_comb begin
      sq_f_ff[0] = s3_ff;
      sq_c_ff[0] = cls_ff;
      sq_r_ff[0] = '0;
      sq_q_ff[0] = '0;
      sq_d_ff[0] = (2*SW)'(d3_ff);
   end

   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      logic [DW+1:0] rt, tr;
      assign rt = {sq_r_ff[i][DW-1:0], sq_d_ff[i][2*SW-1 -: 2]};
      assign tr = (DW+2)'({sq_q_ff[i], 2'b01});
      always_ff @(posedge clock) begin
         if (!stall) begin
            sq_f_ff[i+1] <= sq_f_ff[i];
            sq_c_ff[i+1] <= sq_c_ff[i];
            sq_d_ff[i+1] <= sq_d_ff[i] << 2;
            if (rt >= tr) begin
               sq_r_ff[i+1] <= rt - tr;
               sq_q_ff[i+1] <= {sq_q_ff[i][SW-2:0], 1'b1};
            end else begin
               sq_r_ff[i+1] <= rt;
               sq_q_ff[i+1] <= {sq_q_ff[i][SW-2:0], 1'b0};
            end
         end
      end
   end

   // Round square root and form numerators.
   front_type    fs;
   logic [SW:0]  s_rnd;
   logic [NW-1:0] sm, bm;
   quot_type     qn;
   assign fs    = sq_f_ff[SQ];
   assign s_rnd = (sq_r_ff[SQ] > (DW+2)'(sq_q_ff[SQ])) ? (SW+1)'(sq_q_ff[SQ]) + 1'b1
                                                      : (SW+1)'(sq_q_ff[SQ]);
   assign sm    = NW'(s_rnd);
   assign bm    = NW'(fs.mb);

   always_comb begin
      qn     = '0;
      qn.cnt = sq_c_ff[SQ];
      if (fs.ma == '0) begin
         qn.n1  = (!fs.nc) != fs.nb;
         qn.m1  = NW'(fs.mc);
         qn.den = DNW'(fs.mb);
      end else begin
         qn.den = {fs.ma, 1'b0};
         if (sq_c_ff[SQ] == qrs_pkg::CNT_ONE) begin
            qn.n1 = (!fs.nb) != fs.na;
            qn.m1 = bm;
         end else begin
            // -b + s
            if (fs.nb) begin
               qn.n1 = fs.na; qn.m1 = bm + sm;
            end else if (bm >= sm) begin
               qn.n1 = !fs.na; qn.m1 = bm - sm;
            end else begin
               qn.n1 = fs.na; qn.m1 = sm - bm;
            end
            // -b - s
            if (!fs.nb) begin
               qn.n2 = !fs.na; qn.m2 = bm + sm;
            end else if (bm >= sm) begin
               qn.n2 = fs.na; qn.m2 = bm - sm;
            end else begin
               qn.n2 = !fs.na; qn.m2 = sm - bm;
            end
         end
      end
   end

   // Two restoring dividers, one quotient bit a stage.
   quot_type      dv_h_ff [DV+1];
   logic [QW-1:0] dv_n1_ff [DV+1], dv_n2_ff [DV+1];
   logic [RW-1:0] dv_r1_ff [DV+1], dv_r2_ff [DV+1];

   always_comb begin
      dv_h_ff[0]  = qn;
      dv_n1_ff[0] = {qn.m1, {FRAC_BITS{1'b0}}};
      dv_n2_ff[0] = {qn.m2, {FRAC_BITS{1'b0}}};
      dv_r1_ff[0] = '0;
      dv_r2_ff[0] = '0;
   end

   for (genvar i = 0; i < DV; i++) begin : g_div
      logic [RW-1:0] t1, t2;
      assign t1 = {dv_r1_ff[i][RW-2:0], dv_n1_ff[i][QW-1]};
      assign t2 = {dv_r2_ff[i][RW-2:0], dv_n2_ff[i][QW-1]};
      always_ff @(posedge clock) begin
         if (!stall) begin
            dv_h_ff[i+1] <= dv_h_ff[i];
            if (t1 >= RW'(dv_h_ff[i].den)) begin
               dv_r1_ff[i+1] <= t1 - RW'(dv_h_ff[i].den);
               dv_n1_ff[i+1] <= {dv_n1_ff[i][QW-2:0], 1'b1};
            end else begin
               dv_r1_ff[i+1] <= t1;
               dv_n1_ff[i+1] <= {dv_n1_ff[i][QW-2:0], 1'b0};
            end
            if (t2 >= RW'(dv_h_ff[i].den)) begin
               dv_r2_ff[i+1] <= t2 - RW'(dv_h_ff[i].den);
               dv_n2_ff[i+1] <= {dv_n2_ff[i][QW-2:0], 1'b1};
            end else begin
               dv_r2_ff[i+1] <= t2;
               dv_n2_ff[i+1] <= {dv_n2_ff[i][QW-2:0], 1'b0};
            end
         end
      end
   end

   // Rounding, saturation and output register.
   function automatic logic [W:0] pack_root(input logic neg, input logic [QW-1:0] q,
                                            input logic [RW-1:0] r,
                                            input logic [DNW-1:0] den);
      logic [QW:0]  qr;
      logic [W-1:0] lim;
      logic         sat;
      logic [W-1:0] m;
      qr  = (r >= RW'(den) - r) ? (QW+1)'(q) + 1'b1 : (QW+1)'(q);
      lim = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      sat = 1'b0;
      if (qr == '0) begin
         m = '0;
      end else if (qr > (QW+1)'(lim)) begin
         m = lim; sat = 1'b1;
      end else begin
         m = qr[W-1:0];
      end
      return {sat, neg ? W'(-m) : m};
   endfunction

   quot_type     ho;
   logic [W:0]   p1, p2;
   assign ho = dv_h_ff[DV];
   assign p1 = pack_root(ho.n1, dv_n1_ff[DV], dv_r1_ff[DV], ho.den);
   assign p2 = pack_root(ho.n2, dv_n2_ff[DV], dv_r2_ff[DV], ho.den);

   logic [1:0]   cnt_ff;
   logic [W-1:0] r1_ff, r2_ff;
   logic         sat_ff;
   always_ff @(posedge clock) begin
      if (!stall) begin
         cnt_ff <= ho.cnt;
         case (ho.cnt)
            qrs_pkg::CNT_ONE: begin
               r1_ff <= p1[W-1:0]; r2_ff <= '0; sat_ff <= p1[W];
            end
            qrs_pkg::CNT_TWO: begin
               r1_ff <= p1[W-1:0]; r2_ff <= p2[W-1:0]; sat_ff <= p1[W] | p2[W];
            end
            default: begin
               r1_ff <= '0; r2_ff <= '0; sat_ff <= 1'b0;
            end
         endcase
      end
   end

   assign rsp.valid       = vld_ff[NST-1];
   assign rsp.root_count  = cnt_ff;
   assign rsp.root_first  = r1_ff;
   assign rsp.root_second = r2_ff;
   assign rsp.saturated   = sat_ff;

endmodule
